// ===== sv/qcps_pkg.sv =====
// Package for the quadrature clock plan search block.
// Holds request and result types, search limits and the divider request and response types.
// No dependencies.
package qcps_pkg;

  localparam int unsigned REF_W  = 32;
  localparam int unsigned REQ_W  = 32;
  localparam int unsigned MULT_W = 7;
  localparam int unsigned DIVR_W = 7;
  localparam int unsigned VCO_W  = 30;
  localparam int unsigned ACT_W  = 27;
  localparam int unsigned ERR_W  = 32;
  // reference times the largest multiplier
  localparam int unsigned ACC_W  = REF_W + MULT_W;

  localparam logic [MULT_W-1:0] MULT_FIRST = 7'd15;
  localparam logic [MULT_W-1:0] MULT_LAST  = 7'd90;
  localparam logic [DIVR_W-1:0] DIV_FIRST  = 7'd8;
  localparam logic [DIVR_W-1:0] DIV_STEP   = 7'd4;
  localparam logic [DIVR_W-1:0] DIV_LAST   = 7'd124;

  localparam logic [ACC_W-1:0] PLL_MIN_HZ = 39'd600000000;
  localparam logic [ACC_W-1:0] PLL_MAX_HZ = 39'd900000000;

  // one quotient bit per cycle
  localparam int unsigned DIV_STEPS = VCO_W;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [REF_W-1:0] reference_freq;
    logic [REQ_W-1:0] requested_freq;
  } qcps_in_t;

  typedef struct packed {
    logic              found;
    logic [MULT_W-1:0] pll_mult;
    logic [DIVR_W-1:0] out_divider;
    logic [DIVR_W-1:0] phase_step;
    logic [VCO_W-1:0]  vco_freq;
    logic [ACT_W-1:0]  achieved_freq;
    logic [ERR_W-1:0]  freq_error;
  } qcps_out_t;

  typedef struct packed {
    logic              start;
    logic [VCO_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } qcps_div_req_t;

  typedef struct packed {
    logic             done;
    logic [VCO_W-1:0] quotient;
  } qcps_div_rsp_t;

endpackage

// ===== sv/qcps_div.sv =====
// Bit-serial restoring divider: PLL frequency over output divider.
// One quotient bit per cycle; done pulses once the last bit is in. Uses qcps_pkg.
module qcps_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  qcps_pkg::qcps_div_req_t req,
  output qcps_pkg::qcps_div_rsp_t rsp
);
  import qcps_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [VCO_W-1:0]  dvd_r, dvd_nxt;
  logic [DIVR_W-1:0] dvs_r, dvs_nxt;
  logic [DIVR_W-1:0] rem_r, rem_nxt;
  logic [VCO_W-1:0]  quo_r, quo_nxt;
  logic [DIVR_W:0]   rem_sh;
  logic [DIVR_W:0]   rem_sub;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[VCO_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    ge      = (rem_sh >= {1'b0, dvs_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(DIV_STEPS - 1);
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      // remainder stays below the divisor, so seven bits hold it
      rem_nxt = ge ? rem_sub[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
      quo_nxt = {quo_r[VCO_W-2:0], ge};
      dvd_nxt = {dvd_r[VCO_W-2:0], 1'b0};
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== sv/quadrature_clock_plan_search.sv =====
// Quadrature clock plan search: tries each multiplier in turn and, where the
// PLL frequency is in range, runs each of the 30 dividers through the serial
// divider; one request at a time.
// The result waits in an output register, and the next request is taken meanwhile.
// Synchronous active-low reset clears the sequencer, divider and output valid.
// Uses qcps_pkg and qcps_div.
module quadrature_clock_plan_search (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  qcps_pkg::qcps_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qcps_pkg::qcps_out_t out_data
);
  import qcps_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_INIT  = 6'b000010,
    S_CHECK = 6'b000100,
    S_DIV   = 6'b001000,
    S_CMP   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [REF_W-1:0]  ref_r, ref_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [MULT_W-1:0] mult_r, mult_nxt;
  logic [DIVR_W-1:0] div_r, div_nxt;
  logic [ACT_W-1:0]  act_r, act_nxt;
  logic [ERR_W-1:0]  err_r, err_nxt;
  logic              have_r, have_nxt;
  logic [MULT_W-1:0] b_mult_r, b_mult_nxt;
  logic [DIVR_W-1:0] b_div_r, b_div_nxt;
  logic [VCO_W-1:0]  b_vco_r, b_vco_nxt;
  logic [ACT_W-1:0]  b_act_r, b_act_nxt;
  logic [ERR_W-1:0]  b_err_r, b_err_nxt;
  logic              out_valid_r, out_valid_nxt;
  qcps_out_t         out_data_r, out_data_nxt;

  qcps_div_req_t     div_req;
  qcps_div_rsp_t     div_rsp;

  logic [ACC_W-1:0]  ref_ext;
  logic              in_range;
  logic              better;
  logic [ERR_W-1:0]  act_ext;

  qcps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    ref_ext  = {{(ACC_W-REF_W){1'b0}}, ref_r};
    in_range = (acc_r >= PLL_MIN_HZ) && (acc_r <= PLL_MAX_HZ);
    act_ext  = {{(ERR_W-ACT_W){1'b0}}, div_rsp.quotient[ACT_W-1:0]};
    better   = !have_r || (err_r < b_err_r) || ((err_r == b_err_r) && (act_r < b_act_r));
  end

  always_comb begin
    state_nxt     = state_r;
    ref_nxt       = ref_r;
    req_nxt       = req_r;
    acc_nxt       = acc_r;
    mult_nxt      = mult_r;
    div_nxt       = div_r;
    act_nxt       = act_r;
    err_nxt       = err_r;
    have_nxt      = have_r;
    b_mult_nxt    = b_mult_r;
    b_div_nxt     = b_div_r;
    b_vco_nxt     = b_vco_r;
    b_act_nxt     = b_act_r;
    b_err_nxt     = b_err_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    div_req.start    = 1'b0;
    div_req.dividend = acc_r[VCO_W-1:0];
    div_req.divisor  = DIV_FIRST;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ref_nxt    = in_data.reference_freq;
          req_nxt    = in_data.requested_freq;
          have_nxt   = 1'b0;
          b_mult_nxt = '0;
          b_div_nxt  = '0;
          b_vco_nxt  = '0;
          b_act_nxt  = '0;
          b_err_nxt  = '0;
          state_nxt  = S_INIT;
        end
      end
      S_INIT: begin
        // reference times the first multiplier, 16x minus 1x
        acc_nxt   = (ref_ext << 4) - ref_ext;
        mult_nxt  = MULT_FIRST;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (in_range) begin
          div_nxt         = DIV_FIRST;
          div_req.start   = 1'b1;
          div_req.divisor = DIV_FIRST;
          state_nxt       = S_DIV;
        end else if (mult_r == MULT_LAST) begin
          state_nxt = S_DONE;
        end else begin
          mult_nxt = mult_r + MULT_W'(1);
          acc_nxt  = acc_r + ref_ext;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          act_nxt   = div_rsp.quotient[ACT_W-1:0];
          err_nxt   = (act_ext > req_r) ? (act_ext - req_r) : (req_r - act_ext);
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (better) begin
          have_nxt   = 1'b1;
          b_mult_nxt = mult_r;
          b_div_nxt  = div_r;
          b_vco_nxt  = acc_r[VCO_W-1:0];
          b_act_nxt  = act_r;
          b_err_nxt  = err_r;
        end
        if (div_r != DIV_LAST) begin
          div_nxt         = div_r + DIV_STEP;
          div_req.start   = 1'b1;
          div_req.divisor = div_r + DIV_STEP;
          state_nxt       = S_DIV;
        end else if (mult_r == MULT_LAST) begin
          state_nxt = S_DONE;
        end else begin
          mult_nxt  = mult_r + MULT_W'(1);
          acc_nxt   = acc_r + ref_ext;
          state_nxt = S_CHECK;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.found         = have_r;
          out_data_nxt.pll_mult      = b_mult_r;
          out_data_nxt.out_divider   = b_div_r;
          out_data_nxt.phase_step    = b_div_r;
          out_data_nxt.vco_freq      = b_vco_r;
          out_data_nxt.achieved_freq = b_act_r;
          out_data_nxt.freq_error    = b_err_r;
          out_valid_nxt              = 1'b1;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ref_r      <= ref_nxt;
    req_r      <= req_nxt;
    acc_r      <= acc_nxt;
    mult_r     <= mult_nxt;
    div_r      <= div_nxt;
    act_r      <= act_nxt;
    err_r      <= err_nxt;
    have_r     <= have_nxt;
    b_mult_r   <= b_mult_nxt;
    b_div_r    <= b_div_nxt;
    b_vco_r    <= b_vco_nxt;
    b_act_r    <= b_act_nxt;
    b_err_r    <= b_err_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/qcps_chk.sv =====
// Port-level checker for the quadrature clock plan search block.
// Bound to quadrature_clock_plan_search; uses qcps_pkg.
module qcps_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input qcps_pkg::qcps_out_t out_data
);
  import qcps_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // reset empties the output register and opens the input
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result valid or input stalled after reset");

  // an accepted request closes the input while the search runs
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a request");

  // a miss reports all zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      out_data.pll_mult == '0 && out_data.out_divider == '0 &&
      out_data.phase_step == '0 && out_data.vco_freq == '0 &&
      out_data.achieved_freq == '0 && out_data.freq_error == '0)
    else $error("miss with nonzero fields");

  // a hit reports a legal plan with the PLL in range
  a_hit_plan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |->
      out_data.phase_step == out_data.out_divider &&
      out_data.out_divider >= DIV_FIRST && out_data.out_divider <= DIV_LAST &&
      out_data.out_divider[1:0] == 2'b00 &&
      out_data.pll_mult >= MULT_FIRST && out_data.pll_mult <= MULT_LAST &&
      {{(ACC_W-VCO_W){1'b0}}, out_data.vco_freq} >= PLL_MIN_HZ &&
      {{(ACC_W-VCO_W){1'b0}}, out_data.vco_freq} <= PLL_MAX_HZ)
    else $error("illegal multiplier, divider or PLL frequency");

endmodule

bind quadrature_clock_plan_search qcps_chk u_qcps_chk (.*);

// ===== sim/quadrature_clock_plan_search_checker.sv =====
// Checker for the quadrature clock plan search block.
// Watches both channels, predicts each plan and compares it field by field.
// Depends on qcps_pkg.
`timescale 1ns / 100ps

module quadrature_clock_plan_search_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  qcps_pkg::qcps_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  qcps_pkg::qcps_out_t out_data,
  output int                  mismatch_count,
  output int                  plans_pending
);
  import qcps_pkg::*;

  qcps_out_t plan_q[$];
  int        errors = 0;

  // Exhaustive search over multiplier and divider; strict compares keep the
  // first candidate in search order on a full tie.
  function automatic qcps_out_t search_plan(qcps_in_t rq);
    logic [63:0] ref_hz;
    logic [63:0] req_hz;
    logic [63:0] vco;
    logic [63:0] act;
    logic [63:0] err;
    logic [63:0] best_act;
    logic [63:0] best_err;
    bit          have;
    qcps_out_t   best;
    ref_hz   = {32'd0, rq.reference_freq};
    req_hz   = {32'd0, rq.requested_freq};
    best     = '0;
    best_act = '0;
    best_err = '0;
    have     = 1'b0;
    for (int m = int'(MULT_FIRST); m <= int'(MULT_LAST); m++) begin
      vco = ref_hz * 64'(m);
      if (vco < 64'(PLL_MIN_HZ) || vco > 64'(PLL_MAX_HZ)) continue;
      for (int d = int'(DIV_FIRST); d <= int'(DIV_LAST); d += int'(DIV_STEP)) begin
        act = vco / 64'(d);
        err = (act > req_hz) ? act - req_hz : req_hz - act;
        if (!have || err < best_err || (err == best_err && act < best_act)) begin
          have               = 1'b1;
          best_act           = act;
          best_err           = err;
          best.found         = 1'b1;
          best.pll_mult      = MULT_W'(m);
          best.out_divider   = DIVR_W'(d);
          best.phase_step    = DIVR_W'(d);
          best.vco_freq      = vco[VCO_W-1:0];
          best.achieved_freq = act[ACT_W-1:0];
          best.freq_error    = err[ERR_W-1:0];
        end
      end
    end
    return best;
  endfunction

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    qcps_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) plan_q.push_back(search_plan(in_data));
      if (out_valid && !out_stall) begin
        if (plan_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          want = plan_q.pop_front();
          flag_field("found", 32'(want.found), 32'(out_data.found));
          flag_field("pll_mult", 32'(want.pll_mult), 32'(out_data.pll_mult));
          flag_field("out_divider", 32'(want.out_divider), 32'(out_data.out_divider));
          flag_field("phase_step", 32'(want.phase_step), 32'(out_data.phase_step));
          flag_field("vco_freq", 32'(want.vco_freq), 32'(out_data.vco_freq));
          flag_field("achieved_freq", 32'(want.achieved_freq),
                     32'(out_data.achieved_freq));
          flag_field("freq_error", want.freq_error, out_data.freq_error);
        end
      end
    end
    mismatch_count <= errors;
    plans_pending  <= plan_q.size();
  end

endmodule

// ===== sim/quadrature_clock_plan_search_tb.sv =====
// Testbench top for the quadrature clock plan search block.
// Drives plan requests and result stalls; the checker predicts and compares.
// Depends on qcps_pkg, quadrature_clock_plan_search and its checker.
`timescale 1ns / 100ps

module quadrature_clock_plan_search_tb;
  import qcps_pkg::*;

  // the limit covers the worst search, idling and several times over
  localparam int CYCLE_LIMIT  = 15_000_000;
  localparam int RANDOM_PLANS = 85;
  localparam int TAIL_CYCLES  = 40;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  qcps_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  qcps_out_t out_data;
  int        mismatch_count;
  int        plans_pending;
  int        cycles = 0;
  bit        calm;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quadrature_clock_plan_search DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  quadrature_clock_plan_search_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .plans_pending  (plans_pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge that accepts the request.
  task automatic send_plan_request(input logic [31:0] ref_hz, input logic [31:0] req_hz);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid               <= 1'b1;
    in_data.reference_freq <= ref_hz;
    in_data.requested_freq <= req_hz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Result side: hold stall for a drawn number of cycles once a result shows.
  initial begin
    int hold;
    out_stall = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 14);
      if (hold > 0) begin
        out_stall <= 1'b1;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
        repeat (hold - 1) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int          pick;
    logic [31:0] ref_hz;
    logic [31:0] req_hz;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    calm      = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes, nothing found
    send_plan_request(32'd0, 32'd0);
    send_plan_request(32'd0, 32'hFFFF_FFFF);
    send_plan_request(32'hFFFF_FFFF, 32'd0);
    send_plan_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // PLL range edges: just below, just inside, exact low and high bounds, just above
    send_plan_request(32'd6_666_666, 32'd1_000_000);
    send_plan_request(32'd6_666_667, 32'd1_000_000);
    send_plan_request(32'd40_000_000, 32'd75_000_000);
    send_plan_request(32'd60_000_000, 32'd112_500_000);
    send_plan_request(32'd60_000_001, 32'd7_000_000);
    // equal achieved frequency from two multipliers: first in search order wins
    send_plan_request(32'd25_000_000, 32'd75_000_000);
    // equal error either side of the request: lower achieved wins
    send_plan_request(32'd50_000_000, 32'd84_375_000);
    // largest divider, densest search, request far above reach
    send_plan_request(32'd25_000_000, 32'd0);
    send_plan_request(32'd10_000_000, 32'd7_100_000);
    send_plan_request(32'd27_000_000, 32'hFFFF_FFFF);
    send_plan_request(32'd12_345_678, 32'd14_200_000);

    for (int i = 0; i < RANDOM_PLANS; i++) begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          ref_hz = $urandom;
          req_hz = $urandom;
        end
        1: begin
          ref_hz = $urandom_range(6_666_667, 60_000_000);
          req_hz = $urandom;
        end
        2: begin
          ref_hz = $urandom_range(0, 1) ? $urandom_range(6_666_000, 6_667_500)
                                        : $urandom_range(59_999_000, 60_001_000);
          req_hz = $urandom_range(0, 115_000_000);
        end
        default: begin
          ref_hz = $urandom_range(6_666_667, 60_000_000);
          req_hz = $urandom_range(0, 115_000_000);
        end
      endcase
      send_plan_request(ref_hz, req_hz);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (plans_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/qcps_pkg.sv
sv/qcps_div.sv
sv/quadrature_clock_plan_search.sv
sv/qcps_chk.sv
sim/quadrature_clock_plan_search_checker.sv
sim/quadrature_clock_plan_search_tb.sv
